[rtl/source_char_tokenizer_core_defines.svh]
// Assertion macros shared by the tokenizer RTL.
`ifndef SOURCE_CHAR_TOKENIZER_CORE_DEFINES_SVH
`define SOURCE_CHAR_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sct_pkg.sv]
// Types and constants shared by the tokenizer modules.
package sct_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    ACT_NONE   = 4'd0,
    ACT_START  = 4'd1,
    ACT_APPEND = 4'd2,
    ACT_RETYPE = 4'd3,
    ACT_FLOAT0 = 4'd4,
    ACT_STRING = 4'd5,
    ACT_BAD    = 4'd6,
    ACT_POINT2 = 4'd7,
    ACT_END    = 4'd8
  } sct_act_t;

  localparam logic [4:0] KIND_IDENT   = 5'd0;
  localparam logic [4:0] KIND_INT     = 5'd1;
  localparam logic [4:0] KIND_FLOAT   = 5'd2;
  localparam logic [4:0] KIND_STRING  = 5'd3;
  localparam logic [4:0] KIND_END     = 5'd4;
  localparam logic [4:0] KIND_ADD     = 5'd5;
  localparam logic [4:0] KIND_SUB     = 5'd6;
  localparam logic [4:0] KIND_MUL     = 5'd7;
  localparam logic [4:0] KIND_DIV     = 5'd8;
  localparam logic [4:0] KIND_MOD     = 5'd9;
  localparam logic [4:0] KIND_ASSIGN  = 5'd10;
  localparam logic [4:0] KIND_ADD_EQ  = 5'd11;
  localparam logic [4:0] KIND_SUB_EQ  = 5'd12;
  localparam logic [4:0] KIND_MUL_EQ  = 5'd13;
  localparam logic [4:0] KIND_DIV_EQ  = 5'd14;
  localparam logic [4:0] KIND_INCDEC  = 5'd15;
  localparam logic [4:0] KIND_EQ      = 5'd16;
  localparam logic [4:0] KIND_NE      = 5'd17;
  localparam logic [4:0] KIND_NOT     = 5'd18;
  localparam logic [4:0] KIND_GT      = 5'd19;
  localparam logic [4:0] KIND_GE      = 5'd20;
  localparam logic [4:0] KIND_LT      = 5'd21;
  localparam logic [4:0] KIND_LE      = 5'd22;
  localparam logic [4:0] KIND_LTGT    = 5'd23;
  localparam logic [4:0] KIND_OR      = 5'd24;
  localparam logic [4:0] KIND_AND     = 5'd25;
  localparam logic [4:0] KIND_LPAREN  = 5'd26;
  localparam logic [4:0] KIND_RPAREN  = 5'd27;
  localparam logic [4:0] KIND_LBRACK  = 5'd28;
  localparam logic [4:0] KIND_RBRACK  = 5'd29;
  localparam logic [4:0] KIND_NONE    = 5'd31;

  typedef enum logic [3:0] {
    CLS_ZERO,
    CLS_NEWLINE,
    CLS_IGNORE,
    CLS_SEMI,
    CLS_QUOTE,
    CLS_SPACE,
    CLS_OPER,
    CLS_IDENT,
    CLS_DIGIT,
    CLS_POINT,
    CLS_BAD
  } sct_cls_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_code;
    logic [7:0] lookahead;
    logic       has_next;
  } sct_req_t;

  typedef struct packed {
    sct_act_t    token_action;
    logic [4:0]  token_kind;
    logic [7:0]  char_out;
    logic [15:0] row;
    logic [15:0] column;
    logic        error_seen;
  } sct_rsp_t;

  typedef struct packed {
    logic       end_text;
    sct_cls_t   cls;
    logic [4:0] op_kind;
    logic       two_char;
    logic [7:0] char_code;
  } sct_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sct_qstat_t;

endpackage

[rtl/sct_front.sv]
// Front end: classifies each request byte and resolves operator lookahead.
module sct_front (
  input  sct_pkg::sct_req_t  req,
  output sct_pkg::sct_item_t item
);

  logic       eq_next;
  logic [4:0] op_kind;
  logic       two_char;

  always_comb begin
    eq_next  = req.has_next && (req.lookahead == 8'h3D);
    op_kind  = 5'd0;
    two_char = 1'b0;
    case (req.char_code)
      8'h28: op_kind = sct_pkg::KIND_LPAREN;
      8'h29: op_kind = sct_pkg::KIND_RPAREN;
      8'h25: op_kind = sct_pkg::KIND_MOD;
      8'h7C: op_kind = sct_pkg::KIND_OR;
      8'h26: op_kind = sct_pkg::KIND_AND;
      8'h5B: op_kind = sct_pkg::KIND_LBRACK;
      8'h5D: op_kind = sct_pkg::KIND_RBRACK;
      8'h2B: begin
        if (eq_next) begin
          op_kind = sct_pkg::KIND_ADD_EQ;
          two_char = 1'b1;
        end else if (req.has_next && req.lookahead == 8'h2B) begin
          op_kind = sct_pkg::KIND_INCDEC;
          two_char = 1'b1;
        end else begin
          op_kind = sct_pkg::KIND_ADD;
        end
      end
      8'h2D: begin
        if (eq_next) begin
          op_kind = sct_pkg::KIND_SUB_EQ;
          two_char = 1'b1;
        end else if (req.has_next && req.lookahead == 8'h2D) begin
          op_kind = sct_pkg::KIND_INCDEC;
          two_char = 1'b1;
        end else begin
          op_kind = sct_pkg::KIND_SUB;
        end
      end
      8'h3E: begin
        op_kind = eq_next ? sct_pkg::KIND_GE : sct_pkg::KIND_GT;
        two_char = eq_next;
      end
      8'h3C: begin
        if (eq_next) begin
          op_kind = sct_pkg::KIND_LE;
          two_char = 1'b1;
        end else if (req.has_next && req.lookahead == 8'h3E) begin
          op_kind = sct_pkg::KIND_LTGT;
          two_char = 1'b1;
        end else begin
          op_kind = sct_pkg::KIND_LT;
        end
      end
      8'h2A: begin
        op_kind = eq_next ? sct_pkg::KIND_MUL_EQ : sct_pkg::KIND_MUL;
        two_char = eq_next;
      end
      8'h2F: begin
        op_kind = eq_next ? sct_pkg::KIND_DIV_EQ : sct_pkg::KIND_DIV;
        two_char = eq_next;
      end
      8'h3D: begin
        op_kind = eq_next ? sct_pkg::KIND_EQ : sct_pkg::KIND_ASSIGN;
        two_char = eq_next;
      end
      8'h21: begin
        op_kind = eq_next ? sct_pkg::KIND_NE : sct_pkg::KIND_NOT;
        two_char = eq_next;
      end
      default: op_kind = 5'd0;
    endcase
  end

  always_comb begin
    item.end_text  = req.operation;
    item.op_kind   = op_kind;
    item.two_char  = two_char;
    item.char_code = req.char_code;
    if (req.char_code == 8'h00) begin
      item.cls = sct_pkg::CLS_ZERO;
    end else if (req.char_code == 8'h0A) begin
      item.cls = sct_pkg::CLS_NEWLINE;
    end else if (req.char_code == 8'h0D || req.char_code == 8'hFF) begin
      item.cls = sct_pkg::CLS_IGNORE;
    end else if (req.char_code == 8'h3B) begin
      item.cls = sct_pkg::CLS_SEMI;
    end else if (req.char_code == 8'h22) begin
      item.cls = sct_pkg::CLS_QUOTE;
    end else if (req.char_code == 8'h20) begin
      item.cls = sct_pkg::CLS_SPACE;
    end else if (op_kind != 5'd0) begin
      item.cls = sct_pkg::CLS_OPER;
    end else if (req.char_code inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F, 8'h3F, 8'h40}) begin
      item.cls = sct_pkg::CLS_IDENT;
    end else if (req.char_code inside {[8'h30:8'h39]}) begin
      item.cls = sct_pkg::CLS_DIGIT;
    end else if (req.char_code == 8'h2E) begin
      item.cls = sct_pkg::CLS_POINT;
    end else begin
      item.cls = sct_pkg::CLS_BAD;
    end
  end

endmodule

[rtl/sct_queue.sv]
// Short queue of classified items between the front and back ends.
`include "source_char_tokenizer_core_defines.svh"

module sct_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sct_pkg::sct_item_t  push_item,
  input  logic                pop,
  output sct_pkg::sct_item_t  pop_item,
  output sct_pkg::sct_qstat_t stat
);

  sct_pkg::sct_item_t                   mem [sct_pkg::QUEUE_DEPTH];
  logic [sct_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr;
  logic [sct_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr;
  logic [sct_pkg::QUEUE_CNT_BITS-1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign pop_item   = mem[rd_ptr];
  assign stat.full  = (count == sct_pkg::QUEUE_CNT_BITS'(sct_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  `SCT_ASSERT_NOW(a_no_overflow, clk, rst, push, !stat.full, "Push into a full queue.")
  `SCT_ASSERT_NOW(a_no_underflow, clk, rst, pop, !stat.empty, "Pop from an empty queue.")

endmodule

[rtl/sct_back.sv]
// Back end: token state, position counters and the registered response.
`include "source_char_tokenizer_core_defines.svh"

module sct_back #(
  parameter int POSITION_BITS = sct_pkg::POSITION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  sct_pkg::sct_item_t  item,
  input  sct_pkg::sct_qstat_t stat,
  output logic                pop,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output sct_pkg::sct_rsp_t   rsp_data
);

  logic                     after_space, after_space_next;
  logic                     in_comment, in_comment_next;
  logic                     in_string, in_string_next;
  logic [4:0]               last_kind, last_kind_next;
  logic                     skip_second, skip_second_next;
  logic [POSITION_BITS-1:0] row_count, row_count_next;
  logic [POSITION_BITS-1:0] column_count, column_count_next;
  logic                     error_flag, error_flag_next;
  sct_pkg::sct_rsp_t        rsp_next;
  logic                     count_col;
  logic [POSITION_BITS-1:0] row_inc;
  logic [POSITION_BITS-1:0] col_inc;

  assign pop     = !stat.empty && (!rsp_valid || !rsp_stall);
  assign row_inc = (row_count == '1) ? row_count : row_count + 1'b1;
  assign col_inc = (column_count == '1) ? column_count : column_count + 1'b1;

  always_comb begin
    after_space_next  = after_space;
    in_comment_next   = in_comment;
    in_string_next    = in_string;
    last_kind_next    = last_kind;
    skip_second_next  = skip_second;
    row_count_next    = row_count;
    column_count_next = column_count;
    error_flag_next   = error_flag;
    count_col         = 1'b1;
    rsp_next.token_action = sct_pkg::ACT_NONE;
    rsp_next.token_kind   = sct_pkg::KIND_IDENT;
    rsp_next.char_out     = 8'h00;
    rsp_next.row          = 16'(row_count);
    rsp_next.column       = 16'(column_count);

    if (item.end_text) begin
      rsp_next.token_action = sct_pkg::ACT_END;
      rsp_next.token_kind   = sct_pkg::KIND_END;
      count_col         = 1'b0;
      after_space_next  = 1'b0;
      in_comment_next   = 1'b0;
      in_string_next    = 1'b0;
      last_kind_next    = sct_pkg::KIND_NONE;
      skip_second_next  = 1'b0;
      row_count_next    = '0;
      column_count_next = '0;
      error_flag_next   = 1'b0;
    end else if (skip_second) begin
      skip_second_next = 1'b0;
    end else begin
      case (item.cls)
        sct_pkg::CLS_ZERO: begin
          rsp_next.token_action = sct_pkg::ACT_END;
          rsp_next.token_kind   = sct_pkg::KIND_END;
          last_kind_next = sct_pkg::KIND_END;
        end
        sct_pkg::CLS_NEWLINE: begin
          after_space_next  = 1'b1;
          in_comment_next   = 1'b0;
          row_count_next    = row_inc;
          column_count_next = '0;
          count_col         = 1'b0;
        end
        sct_pkg::CLS_IGNORE: count_col = 1'b0;
        default: begin
          if (item.cls == sct_pkg::CLS_SEMI && in_string) begin
            rsp_next.token_action = sct_pkg::ACT_APPEND;
            rsp_next.token_kind   = last_kind;
            rsp_next.char_out     = item.char_code;
          end else if (item.cls == sct_pkg::CLS_SEMI) begin
            in_comment_next = 1'b1;
          end else if (in_comment) begin
            count_col = 1'b0;
          end else if (item.cls == sct_pkg::CLS_QUOTE) begin
            in_string_next = !in_string;
            if (!in_string) begin
              rsp_next.token_action = sct_pkg::ACT_STRING;
              rsp_next.token_kind   = sct_pkg::KIND_STRING;
              last_kind_next = sct_pkg::KIND_STRING;
            end
          end else if (in_string) begin
            rsp_next.token_action = sct_pkg::ACT_APPEND;
            rsp_next.token_kind   = last_kind;
            rsp_next.char_out     = item.char_code;
          end else begin
            case (item.cls)
              sct_pkg::CLS_SPACE: after_space_next = 1'b1;
              sct_pkg::CLS_OPER: begin
                rsp_next.token_action = sct_pkg::ACT_START;
                rsp_next.token_kind   = item.op_kind;
                rsp_next.char_out     = item.char_code;
                last_kind_next   = item.op_kind;
                skip_second_next = item.two_char;
              end
              sct_pkg::CLS_IDENT: begin
                rsp_next.char_out   = item.char_code;
                rsp_next.token_kind = sct_pkg::KIND_IDENT;
                if (!after_space && last_kind == sct_pkg::KIND_IDENT) begin
                  rsp_next.token_action = sct_pkg::ACT_APPEND;
                end else begin
                  rsp_next.token_action = sct_pkg::ACT_START;
                  last_kind_next = sct_pkg::KIND_IDENT;
                end
                after_space_next = 1'b0;
              end
              sct_pkg::CLS_DIGIT: begin
                rsp_next.char_out = item.char_code;
                if (!after_space && (last_kind == sct_pkg::KIND_INT ||
                    last_kind == sct_pkg::KIND_FLOAT || last_kind == sct_pkg::KIND_IDENT)) begin
                  rsp_next.token_action = sct_pkg::ACT_APPEND;
                  rsp_next.token_kind   = last_kind;
                end else begin
                  rsp_next.token_action = sct_pkg::ACT_START;
                  rsp_next.token_kind   = sct_pkg::KIND_INT;
                  last_kind_next = sct_pkg::KIND_INT;
                end
                after_space_next = 1'b0;
              end
              sct_pkg::CLS_POINT: begin
                rsp_next.char_out   = item.char_code;
                rsp_next.token_kind = sct_pkg::KIND_FLOAT;
                if (last_kind == sct_pkg::KIND_INT) begin
                  rsp_next.token_action = sct_pkg::ACT_RETYPE;
                  last_kind_next   = sct_pkg::KIND_FLOAT;
                  after_space_next = 1'b0;
                end else if (last_kind == sct_pkg::KIND_FLOAT) begin
                  rsp_next.token_action = sct_pkg::ACT_POINT2;
                  error_flag_next = 1'b1;
                end else begin
                  rsp_next.token_action = sct_pkg::ACT_FLOAT0;
                  last_kind_next   = sct_pkg::KIND_FLOAT;
                  after_space_next = 1'b0;
                end
              end
              default: begin
                rsp_next.token_action = sct_pkg::ACT_BAD;
                rsp_next.char_out     = item.char_code;
                error_flag_next = 1'b1;
              end
            endcase
          end
        end
      endcase
    end

    if (count_col) begin
      column_count_next = col_inc;
    end
    rsp_next.error_seen = item.end_text ? error_flag : error_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      after_space  <= 1'b0;
      in_comment   <= 1'b0;
      in_string    <= 1'b0;
      last_kind    <= sct_pkg::KIND_NONE;
      skip_second  <= 1'b0;
      row_count    <= '0;
      column_count <= '0;
      error_flag   <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (pop) begin
        after_space  <= after_space_next;
        in_comment   <= in_comment_next;
        in_string    <= in_string_next;
        last_kind    <= last_kind_next;
        skip_second  <= skip_second_next;
        row_count    <= row_count_next;
        column_count <= column_count_next;
        error_flag   <= error_flag_next;
        rsp_valid    <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp_data <= rsp_next;
    end
  end

  `SCT_ASSERT_NEXT(a_end_clears, clk, rst, pop && item.end_text,
    row_count == '0 && column_count == '0 && !error_flag && last_kind == sct_pkg::KIND_NONE,
    "End of text did not clear the tokenizer state.")
  `SCT_ASSERT_NEXT(a_error_sticky, clk, rst, error_flag && !(pop && item.end_text),
    error_flag, "Error flag dropped without end of text.")
  `SCT_ASSERT_NEXT(a_rsp_drains, clk, rst, rsp_valid && !rsp_stall && !pop, !rsp_valid,
    "Response stayed valid after it was taken.")

endmodule

[rtl/source_char_tokenizer_core.sv]
// Top level of the source byte tokenizer.
//
//   Channel  Handshake             Payload               Direction
//   req      req_valid/req_stall   sct_req_t req_data    into the block
//   rsp      rsp_valid/rsp_stall   sct_rsp_t rsp_data    out of the block
//
// One request per cycle is sustained while rsp_stall is low; each accepted
// request gives one response, via the queue write and the response register.
// The back end's state update acts on one queued item each time it pops.
// Synchronous reset clears the queue, the token state and the response valid.
// A response stall fills the two-entry queue; req_stall rises when it is full.
module source_char_tokenizer_core #(
  parameter int POSITION_BITS = sct_pkg::POSITION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  sct_pkg::sct_req_t req_data,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output sct_pkg::sct_rsp_t rsp_data
);

  sct_pkg::sct_item_t  front_item;
  sct_pkg::sct_item_t  back_item;
  sct_pkg::sct_qstat_t qstat;
  logic                push;
  logic                pop;

  assign req_stall = qstat.full;
  assign push      = req_valid && !qstat.full;

  sct_front u_front (
    .req  (req_data),
    .item (front_item)
  );

  sct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .pop_item  (back_item),
    .stat      (qstat)
  );

  sct_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .item      (back_item),
    .stat      (qstat),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule
